/* hw/rtl/itr_pkg.sv */
`default_nettype none
package itr_pkg;

   localparam int unsigned VALUE_W    = 12;
   localparam int unsigned SYMBOL_W   = 8;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned NUM_DIGITS = 4;
   localparam int unsigned REM_W      = 14;

   localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;

   // digit positions
   localparam logic [1:0] POS_ONES      = 2'd0;
   localparam logic [1:0] POS_TENS      = 2'd1;
   localparam logic [1:0] POS_HUNDREDS  = 2'd2;
   localparam logic [1:0] POS_THOUSANDS = 2'd3;

   // symbol picks within a digit
   localparam logic [1:0] PICK_ONE  = 2'd0;
   localparam logic [1:0] PICK_FIVE = 2'd1;
   localparam logic [1:0] PICK_TEN  = 2'd2;

   localparam logic [SYMBOL_W-1:0] SYM_NONE = 8'h00;
   localparam logic [SYMBOL_W-1:0] SYM_I    = 8'h49;
   localparam logic [SYMBOL_W-1:0] SYM_V    = 8'h56;
   localparam logic [SYMBOL_W-1:0] SYM_X    = 8'h58;
   localparam logic [SYMBOL_W-1:0] SYM_L    = 8'h4C;
   localparam logic [SYMBOL_W-1:0] SYM_C    = 8'h43;
   localparam logic [SYMBOL_W-1:0] SYM_D    = 8'h44;
   localparam logic [SYMBOL_W-1:0] SYM_M    = 8'h4D;

   typedef struct packed {
      logic                                is_empty;
      logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
   } itr_entry_type;

   // number of characters a decimal digit produces
   function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
      logic [2:0] len;
      case (d)
         4'd1, 4'd5:        len = 3'd1;
         4'd2, 4'd4, 4'd6,
         4'd9:              len = 3'd2;
         4'd3, 4'd7:        len = 3'd3;
         4'd8:              len = 3'd4;
         default:           len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [1:0] digit_pick(input logic [DIGIT_W-1:0] d,
                                             input logic [1:0]         step);
      logic [1:0] pick;
      pick = PICK_ONE;
      case (d)
         4'd4: begin
            if (step == 2'd1) pick = PICK_FIVE;
         end
         4'd5, 4'd6, 4'd7, 4'd8: begin
            if (step == 2'd0) pick = PICK_FIVE;
         end
         4'd9: begin
            if (step == 2'd1) pick = PICK_TEN;
         end
         default: pick = PICK_ONE;
      endcase
      return pick;
   endfunction

   function automatic logic [SYMBOL_W-1:0] pos_sym(input logic [1:0] pos,
                                                   input logic [1:0] pick);
      logic [SYMBOL_W-1:0] sym;
      case (pos)
         POS_ONES:     sym = (pick == PICK_ONE) ? SYM_I : (pick == PICK_FIVE) ? SYM_V : SYM_X;
         POS_TENS:     sym = (pick == PICK_ONE) ? SYM_X : (pick == PICK_FIVE) ? SYM_L : SYM_C;
         POS_HUNDREDS: sym = (pick == PICK_ONE) ? SYM_C : (pick == PICK_FIVE) ? SYM_D : SYM_M;
         default:      sym = SYM_M;
      endcase
      return sym;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/itr_front.sv */
`default_nettype none
module itr_front import itr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [VALUE_W-1:0]    req_value,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output itr_entry_type              push_entry
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_PUSH
   } state_type;

   state_type                          state_ff;
   logic [VALUE_W-1:0]                 rem_ff;
   logic [1:0]                         pos_ff;
   itr_entry_type                      entry_ff;

   logic [VALUE_W-1:0]                 value_sat;
   logic [REM_W-1:0]                   div;
   logic [DIGIT_W-1:0]                 digit_in;
   logic [REM_W-1:0]                   sub_in;
   logic [VALUE_W-1:0]                 rem_in;

   assign value_sat  = (req_value > MAX_VALUE) ? MAX_VALUE : req_value;
   assign req_tready = (state_ff == ST_IDLE);
   assign push_valid = (state_ff == ST_PUSH);
   assign push_entry = entry_ff;

   always_comb begin
      case (pos_ff)
         POS_THOUSANDS: div = REM_W'(1000);
         POS_HUNDREDS:  div = REM_W'(100);
         default:       div = REM_W'(10);
      endcase
   end

   // nine parallel compares pick the digit of this position
   always_comb begin
      digit_in = '0;
      sub_in   = '0;
      for (int k = 1; k <= 9; k++) begin
         if ({2'b00, rem_ff} >= REM_W'(k) * div) begin
            digit_in = DIGIT_W'(k);
            sub_in   = REM_W'(k) * div;
         end
      end
      rem_in = VALUE_W'({2'b00, rem_ff} - sub_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  rem_ff            <= value_sat;
                  pos_ff            <= POS_THOUSANDS;
                  entry_ff.is_empty <= (value_sat == '0);
                  entry_ff.digits   <= '0;
                  state_ff          <= ST_CONV;
               end
            end
            ST_CONV: begin
               entry_ff.digits[pos_ff] <= digit_in;
               rem_ff                  <= rem_in;
               pos_ff                  <= pos_ff - 2'd1;
               if (pos_ff == POS_TENS) begin
                  entry_ff.digits[POS_ONES] <= DIGIT_W'(rem_in);
                  state_ff                  <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (push_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/itr_queue.sv */
`default_nettype none
module itr_queue import itr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire itr_entry_type in_entry,
   output logic               out_valid,
   input  wire logic          out_ready,
   output itr_entry_type      out_entry
);

   localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

   itr_entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic                       do_wr;
   logic                       do_rd;

   assign in_ready  = (count_ff != COUNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = mem_ff[rd_ptr_ff];
   assign do_wr     = in_valid && in_ready;
   assign do_rd     = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= in_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd)      count_ff <= count_ff + 1'b1;
         else if (do_rd && !do_wr) count_ff <= count_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/itr_back.sv */
`default_nettype none
module itr_back import itr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire itr_entry_type        pop_entry,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [SYMBOL_W-1:0]       rsp_symbol,
   output logic                      rsp_is_empty,
   output logic                      rsp_last
);

   // highest nonzero digit strictly below limit
   function automatic logic [2:0] find_below(
      input logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits,
      input logic [2:0]                         limit);
      logic [2:0] res;
      res = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if ((3'(i) < limit) && (digits[i] != '0)) res = {1'b1, 2'(i)};
      end
      return res;
   endfunction

   logic                                active_ff;
   logic                                empty_ff;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits_ff;
   logic [1:0]                          pos_ff;
   logic [1:0]                          step_ff;
   logic                                valid_ff;
   logic [SYMBOL_W-1:0]                 symbol_ff;
   logic                                is_empty_ff;
   logic                                last_ff;

   logic [DIGIT_W-1:0]                  cur_digit;
   logic [2:0]                          cur_len;
   logic [SYMBOL_W-1:0]                 cur_sym;
   logic [2:0]                          next_nz;
   logic [2:0]                          start_nz;
   logic                                digit_end;
   logic                                is_last;
   logic                                advance;
   logic                                emit;

   assign cur_digit = digits_ff[pos_ff];
   assign cur_len   = digit_len(cur_digit);
   assign cur_sym   = pos_sym(pos_ff, digit_pick(cur_digit, step_ff));
   assign next_nz   = find_below(digits_ff, {1'b0, pos_ff});
   assign start_nz  = find_below(pop_entry.digits, 3'd4);
   assign digit_end = ({1'b0, step_ff} == cur_len - 3'd1);
   assign is_last   = empty_ff || (digit_end && !next_nz[2]);
   assign advance   = !valid_ff || rsp_tready;
   assign emit      = active_ff && advance;
   assign pop_ready = !active_ff || (emit && is_last);

   assign rsp_tvalid   = valid_ff;
   assign rsp_symbol   = symbol_ff;
   assign rsp_is_empty = is_empty_ff;
   assign rsp_last     = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         if (emit) begin
            valid_ff    <= 1'b1;
            symbol_ff   <= empty_ff ? SYM_NONE : cur_sym;
            is_empty_ff <= empty_ff;
            last_ff     <= is_last;
            if (is_last) begin
               if (!(pop_valid && pop_ready)) active_ff <= 1'b0;
            end else if (digit_end) begin
               pos_ff  <= next_nz[1:0];
               step_ff <= '0;
            end else begin
               step_ff <= step_ff + 2'd1;
            end
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
         // a new request loads in the cycle its predecessor sends its last character
         if (pop_valid && pop_ready) begin
            active_ff <= 1'b1;
            empty_ff  <= pop_entry.is_empty;
            digits_ff <= pop_entry.digits;
            pos_ff    <= start_nz[1:0];
            step_ff   <= '0;
         end
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/integer_to_roman_numeral_unit.sv */
// Integer to Roman numeral converter.
// Input channel req_*: one request per value (0..3999, larger values are
// clamped to 3999). Output channel rsp_*: the numeral as ASCII characters,
// thousands first, one character per beat, rsp_tlast on the final one.
// A zero request yields a single beat with rsp_tuser set, rsp_tdata zero
// and rsp_tlast set.
// After acceptance a request passes through the accept state, three digit
// extraction steps, a queue push, the back end load and the output
// register before its first character appears.
// Throughput: the back end sends one character per cycle while rsp_tready
// is high and a request is loaded; a numeral has 1 to 15 characters.
// The front end accepts a new request only once the previous one has been
// pushed. A two-entry queue between front and back lets the next request
// be converted while characters stream out.
// Stall: when rsp_tready is low the output register holds its beat; the
// back end and then the queue fill, after which req_tready stays low.
// Reset: synchronous, active high; clears all in-flight requests and the
// output valid.
`default_nettype none
module integer_to_roman_numeral_unit import itr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] value, [15:12] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] symbol
   output logic             rsp_tuser,   // [0] is_empty
   output logic             rsp_tlast
);

   logic          push_valid;
   logic          push_ready;
   itr_entry_type push_entry;
   logic          pop_valid;
   logic          pop_ready;
   itr_entry_type pop_entry;

   itr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata[VALUE_W-1:0]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   itr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   itr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_entry    (pop_entry),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_symbol   (rsp_tdata),
      .rsp_is_empty (rsp_tuser),
      .rsp_last     (rsp_tlast)
   );

endmodule
`default_nettype wire

/* hw/rtl/itr_checker.sv */
`default_nettype none
module itr_checker import itr_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // output register is empty right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // an empty beat carries no symbol and is marked last
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == SYM_NONE))
      else $error("empty beat malformed");

   // every real character is a roman symbol
   a_symbol_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         (rsp_tdata == SYM_I || rsp_tdata == SYM_V || rsp_tdata == SYM_X ||
          rsp_tdata == SYM_L || rsp_tdata == SYM_C || rsp_tdata == SYM_D ||
          rsp_tdata == SYM_M))
      else $error("bad symbol");

   // a stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled response changed");

   // a waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=> (req_tvalid && $stable(req_tdata)))
      else $error("waiting request changed");

endmodule

bind integer_to_roman_numeral_unit itr_checker u_itr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
